// ----- sv/tgarle_pkg.sv -----
`default_nettype none
package tgarle_pkg;

  localparam int PIXEL_COUNT_BITS_DEF = 24;
  localparam int TOTAL_W = 25;
  localparam int CFG_DATA_W = 25;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_CODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RUN_LENGTH_MODE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_PIXELS = 2'd2;

  localparam logic [1:0] DEPTH_RESET = 2'd2;
  localparam logic RLM_RESET = 1'b1;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 25'd1;

  localparam logic [7:0] MASK_R16 = 8'h7C;
  localparam logic [7:0] MASK_G16_HI = 8'h03;
  localparam logic [7:0] MASK_G16_LO = 8'hE0;
  localparam logic [7:0] MASK_B16 = 8'h1F;
  localparam logic [7:0] RUN_FLAG = 8'h80;

  typedef enum logic [1:0] {
    DEPTH_8  = 2'd0,
    DEPTH_16 = 2'd1,
    DEPTH_24 = 2'd2,
    DEPTH_32 = 2'd3
  } depth_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_done;
  } out_t;

endpackage
`default_nettype wire

// ----- sv/tgarle_in_stage.sv -----
`default_nettype none
module tgarle_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tgarle_pkg::in_t in_data,
  input  wire logic            advance,
  output logic                 item_valid,
  output tgarle_pkg::in_t      item
);

  logic            valid_r;
  tgarle_pkg::in_t data_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tgarle_decode.sv -----
`default_nettype none
module tgarle_decode #(
  parameter int PIXEL_COUNT_BITS = tgarle_pkg::PIXEL_COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           fire,
  input  wire tgarle_pkg::in_t                item,
  input  wire logic [1:0]                     depth_code,
  input  wire logic                           run_length_mode,
  input  wire logic [tgarle_pkg::TOTAL_W-1:0] total_pixels,
  output logic                                res_valid,
  output tgarle_pkg::out_t                    res
);

  localparam int CW = PIXEL_COUNT_BITS + 1;
  localparam int WW = (CW > tgarle_pkg::TOTAL_W) ? CW : tgarle_pkg::TOTAL_W;
  localparam logic [WW-1:0] LIMIT = WW'(1) << PIXEL_COUNT_BITS;

  logic [7:0]    ppl_r, ppl_nxt;
  logic          is_run_r, is_run_nxt;
  logic [1:0]    bip_r, bip_nxt;
  logic [23:0]   pbytes_r, pbytes_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          fin_r, fin_nxt;

  logic [WW-1:0] total_ext;
  logic [WW-1:0] sat;
  logic [7:0]    b;
  logic [7:0]    lo;
  logic [7:0]    rep;
  logic [CW-1:0] rem_left;

  assign b         = item.data_byte;
  assign total_ext = WW'(total_pixels);
  assign sat       = (total_ext > LIMIT) ? LIMIT : total_ext;

  always_comb begin
    ppl_nxt    = ppl_r;
    is_run_nxt = is_run_r;
    bip_nxt    = bip_r;
    pbytes_nxt = pbytes_r;
    rem_nxt    = rem_r;
    fin_nxt    = fin_r;
    res_valid  = 1'b0;
    res        = '0;
    lo         = 8'd0;
    rep        = 8'd1;
    rem_left   = '0;

    if (item.image_start) begin
      ppl_nxt    = 8'd0;
      is_run_nxt = 1'b0;
      bip_nxt    = 2'd0;
      pbytes_nxt = 24'd0;
      rem_nxt    = sat[CW-1:0];
      fin_nxt    = (sat == '0);
    end

    if (!fin_nxt) begin
      if (run_length_mode && ppl_nxt == 8'd0) begin
        is_run_nxt = (b & tgarle_pkg::RUN_FLAG) != 8'd0;
        ppl_nxt    = (b & ~tgarle_pkg::RUN_FLAG) + 8'd1;
        bip_nxt    = 2'd0;
        pbytes_nxt = 24'd0;
      end else if (bip_nxt < depth_code) begin
        case (bip_nxt)
          2'd0:    pbytes_nxt[7:0]   = pbytes_nxt[7:0] | b;
          2'd1:    pbytes_nxt[15:8]  = pbytes_nxt[15:8] | b;
          2'd2:    pbytes_nxt[23:16] = pbytes_nxt[23:16] | b;
          default: pbytes_nxt        = pbytes_nxt;
        endcase
        bip_nxt = bip_nxt + 2'd1;
      end else begin
        lo = pbytes_nxt[7:0];
        case (depth_code)
          tgarle_pkg::DEPTH_8: begin
            res.red   = b;
            res.green = b;
            res.blue  = b;
          end
          tgarle_pkg::DEPTH_16: begin
            res.red   = (b & tgarle_pkg::MASK_R16) >> 2;
            res.green = ((b & tgarle_pkg::MASK_G16_HI) << 3)
                      | ((lo & tgarle_pkg::MASK_G16_LO) >> 5);
            res.blue  = lo & tgarle_pkg::MASK_B16;
          end
          tgarle_pkg::DEPTH_24: begin
            res.blue  = lo;
            res.green = pbytes_nxt[15:8];
            res.red   = b;
          end
          default: begin
            res.blue  = lo;
            res.green = pbytes_nxt[15:8];
            res.red   = pbytes_nxt[23:16];
            res.alpha = b;
          end
        endcase
        bip_nxt    = 2'd0;
        pbytes_nxt = 24'd0;

        if (run_length_mode && is_run_nxt) begin
          rep     = ppl_nxt;
          ppl_nxt = 8'd0;
        end else begin
          rep = 8'd1;
          if (run_length_mode) begin
            ppl_nxt = ppl_nxt - 8'd1;
          end
        end
        if (CW'(rep) > rem_nxt) begin
          rep = rem_nxt[7:0];
        end
        rem_left = rem_nxt - CW'(rep);
        rem_nxt  = rem_left;
        if (rem_left == '0) begin
          fin_nxt = 1'b1;
        end
        res.repeat_count = rep;
        res.image_done   = fin_nxt;
        res_valid        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppl_r    <= 8'd0;
      is_run_r <= 1'b0;
      bip_r    <= 2'd0;
      pbytes_r <= 24'd0;
      rem_r    <= '0;
      fin_r    <= 1'b1;
    end else if (fire) begin
      ppl_r    <= ppl_nxt;
      is_run_r <= is_run_nxt;
      bip_r    <= bip_nxt;
      pbytes_r <= pbytes_nxt;
      rem_r    <= rem_nxt;
      fin_r    <= fin_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tgarle_out_stage.sv -----
`default_nettype none
module tgarle_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             item_valid,
  input  wire logic             res_valid,
  input  wire tgarle_pkg::out_t res,
  output logic                  advance,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tgarle_pkg::out_t      out_data
);

  logic             valid_r;
  tgarle_pkg::out_t data_r;

  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= item_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid && res_valid) begin
      data_r <= res;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tga_rle_pixel_decoder_core.sv -----
`default_nettype none
// The decoder takes one byte of TGA pixel data per clock while in_ready is high and gives at
// most one pixel, with its repeat count, per byte. A byte is registered on acceptance and
// decoded into the result register once that register can advance. An input register and
// a result register separate the two sides, so one further byte is taken while a result
// waits; the input stalls only when both are full. The user must write configuration only while
// the block is idle, which the block does not enforce; total_pixels takes effect at the next image start.
module tga_rle_pixel_decoder_core #(
  parameter int PIXEL_COUNT_BITS = tgarle_pkg::PIXEL_COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire tgarle_pkg::in_t                   in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output tgarle_pkg::out_t                       out_data,
  input  wire logic                              cfg_we,
  input  wire logic [tgarle_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tgarle_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [1:0]                     depth_r;
  logic                           rlm_r;
  logic [tgarle_pkg::TOTAL_W-1:0] total_r;

  logic             advance;
  logic             item_valid;
  tgarle_pkg::in_t  item;
  logic             res_valid;
  tgarle_pkg::out_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= tgarle_pkg::DEPTH_RESET;
      rlm_r   <= tgarle_pkg::RLM_RESET;
      total_r <= tgarle_pkg::TOTAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tgarle_pkg::CFG_DEPTH_CODE:      depth_r <= cfg_wdata[1:0];
        tgarle_pkg::CFG_RUN_LENGTH_MODE: rlm_r   <= cfg_wdata[0];
        tgarle_pkg::CFG_TOTAL_PIXELS:    total_r <= cfg_wdata[tgarle_pkg::TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  tgarle_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tgarle_decode #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_dec (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (item_valid && advance),
    .item            (item),
    .depth_code      (depth_r),
    .run_length_mode (rlm_r),
    .total_pixels    (total_r),
    .res_valid       (res_valid),
    .res             (res)
  );

  tgarle_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// ----- sv/tgarle_checker.sv -----
`default_nettype none
module tgarle_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire tgarle_pkg::out_t out_data
);

  // A result that is not taken holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.repeat_count != 8'd0)
    else $error("result item with zero repeat count");

  // A new result follows from an item accepted into the input register and then decoded into the result register.
  a_rise_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result item without a preceding input item");

  // The input side stalls only because of a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

endmodule

bind tga_rle_pixel_decoder_core tgarle_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
